// ===== design/jdgs_pkg.sv =====
// Shared widths and types for the job deadline greedy scheduler.
package jdgs_pkg;

  localparam int MAX_JOBS_DEF = 256;
  localparam int DL_W         = 10;
  localparam int PR_W         = 16;
  localparam int CNT_OUT_W    = 9;
  localparam int TOT_OUT_W    = 24;

  // One stored job: deadline and profit.
  typedef struct packed {
    logic [DL_W-1:0] deadline;
    logic [PR_W-1:0] profit;
  } job_t;

endpackage

// ===== design/job_deadline_greedy_scheduler.sv =====
// Job sequencing with deadlines: sorted job store, slot bitmap and greedy scheduler.
//
// Requests carry one job each; the one marked last_job closes the set and
// starts scheduling, after which one result request gives the count of jobs
// that got a slot, their total profit, and whether jobs were dropped because
// the store of MAX_JOBS entries was full. Each job is inserted into a
// profit-ordered memory as it arrives, moving larger-index entries up one at a
// time; the input is stalled until the insertion is done, so no new job is
// taken while one is being placed. Closing a set clears the first n slot
// entries, then reads each job in profit order and walks the slot memory down
// from its clamped deadline until it finds a free slot or reaches slot 1. A
// finished result waits in an output register while the next set is loading.
module job_deadline_greedy_scheduler
  import jdgs_pkg::*;
#(
  parameter int MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DL_W-1:0]      in_job_deadline,
  input  logic [PR_W-1:0]      in_job_profit,
  input  logic                 in_last_job,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CNT_OUT_W-1:0] out_scheduled_count,
  output logic [TOT_OUT_W-1:0] out_total_profit,
  output logic                 out_overflow
);

  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int CMP_W = (CNT_W > DL_W) ? CNT_W : DL_W;
  localparam int TOT_W = PR_W + CNT_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_JOBS);

  typedef enum logic [3:0] {
    S_LOAD, S_INS_RD, S_INS_CMP, S_CLR, S_SCH_RD, S_SCH_GET,
    S_SLT_RD, S_SLT_CHK, S_FIN
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic             ovf_r;
  logic             last_r;
  job_t             new_r;
  logic [CNT_W-1:0] pos_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] slot_r;
  logic [PR_W-1:0]  prof_r;
  logic [CNT_W-1:0] sched_r;
  logic [TOT_W-1:0] total_r;

  logic                 out_valid_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic [TOT_OUT_W-1:0] out_tot_r;
  logic                 out_ovf_r;

  // Job store and slot bitmap memories.
  job_t             job_mem [MAX_JOBS];
  logic             slot_mem [MAX_JOBS];
  logic             job_we;
  logic [IDX_W-1:0] job_wa;
  job_t             job_wd;
  logic [IDX_W-1:0] job_ra;
  job_t             job_rd;
  logic             slot_we;
  logic [IDX_W-1:0] slot_wa;
  logic             slot_wd;
  logic [IDX_W-1:0] slot_ra;
  logic             slot_rd;

  logic             accept;
  logic [CMP_W-1:0] dl_ext;
  logic [CMP_W-1:0] n_ext;
  logic [CNT_W-1:0] dl_clamp;
  logic [TOT_W-1:0] tot_sat;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_LOAD);

  // Deadline clamped to the stored job count.
  assign dl_ext   = CMP_W'(job_rd.deadline);
  assign n_ext    = CMP_W'(count_r);
  assign dl_clamp = (dl_ext > n_ext) ? count_r : CNT_W'(job_rd.deadline);

  // Memory port selection by state.
  always_comb begin
    job_we  = 1'b0;
    job_wa  = pos_r[IDX_W-1:0];
    job_wd  = new_r;
    job_ra  = idx_r[IDX_W-1:0];
    slot_we = 1'b0;
    slot_wa = idx_r[IDX_W-1:0];
    slot_wd = 1'b0;
    slot_ra = slot_r[IDX_W-1:0] - IDX_W'(1);
    unique case (state_r)
      S_LOAD: begin
        job_we = accept && (count_r == '0);
        job_wa = '0;
        job_wd = '{deadline: in_job_deadline, profit: in_job_profit};
      end
      S_INS_RD: begin
        job_ra = pos_r[IDX_W-1:0] - IDX_W'(1);
        job_we = (pos_r == '0);
      end
      S_INS_CMP: begin
        job_we = 1'b1;
        job_wd = (job_rd.profit < new_r.profit) ? job_rd : new_r;
      end
      S_CLR: begin
        slot_we = 1'b1;
      end
      S_SLT_CHK: begin
        slot_we = !slot_rd;
        slot_wa = slot_r[IDX_W-1:0] - IDX_W'(1);
        slot_wd = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (job_we) job_mem[job_wa] <= job_wd;
    job_rd <= job_mem[job_ra];
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd <= slot_mem[slot_ra];
  end

  // Saturation of the profit sum to the output width.
  assign tot_sat = (total_r > TOT_W'({TOT_OUT_W{1'b1}})) ?
                   TOT_W'({TOT_OUT_W{1'b1}}) : total_r;

  // Control sequencer with registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // The finishing state handles the output register itself.
      if (out_valid_r && !out_stall && state_r != S_FIN) out_valid_r <= 1'b0;
      unique case (state_r)
        S_LOAD: begin
          if (accept) begin
            new_r  <= '{deadline: in_job_deadline, profit: in_job_profit};
            last_r <= in_last_job;
            pos_r  <= count_r;
            idx_r  <= '0;
            if (count_r == MAX_CNT) begin
              ovf_r <= 1'b1;
              if (in_last_job) state_r <= S_CLR;
            end else if (count_r == '0) begin
              count_r <= count_r + CNT_W'(1);
              if (in_last_job) state_r <= S_CLR;
            end else begin
              state_r <= S_INS_RD;
            end
          end
        end
        S_INS_RD: begin
          if (pos_r == '0) begin
            count_r <= count_r + CNT_W'(1);
            state_r <= last_r ? S_CLR : S_LOAD;
          end else begin
            state_r <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (job_rd.profit < new_r.profit) begin
            pos_r   <= pos_r - CNT_W'(1);
            state_r <= S_INS_RD;
          end else begin
            count_r <= count_r + CNT_W'(1);
            state_r <= last_r ? S_CLR : S_LOAD;
          end
        end
        S_CLR: begin
          if (idx_r + CNT_W'(1) == count_r) begin
            idx_r   <= '0;
            sched_r <= '0;
            total_r <= '0;
            state_r <= S_SCH_RD;
          end else begin
            idx_r <= idx_r + CNT_W'(1);
          end
        end
        S_SCH_RD: begin
          state_r <= S_SCH_GET;
        end
        S_SCH_GET: begin
          prof_r <= job_rd.profit;
          slot_r <= dl_clamp;
          if (dl_clamp == '0) begin
            idx_r   <= idx_r + CNT_W'(1);
            state_r <= (idx_r + CNT_W'(1) == count_r) ? S_FIN : S_SCH_RD;
          end else begin
            state_r <= S_SLT_RD;
          end
        end
        S_SLT_RD: begin
          state_r <= S_SLT_CHK;
        end
        S_SLT_CHK: begin
          if (!slot_rd || slot_r == CNT_W'(1)) begin
            if (!slot_rd) begin
              sched_r <= sched_r + CNT_W'(1);
              total_r <= total_r + TOT_W'(prof_r);
            end
            idx_r   <= idx_r + CNT_W'(1);
            state_r <= (idx_r + CNT_W'(1) == count_r) ? S_FIN : S_SCH_RD;
          end else begin
            slot_r  <= slot_r - CNT_W'(1);
            state_r <= S_SLT_RD;
          end
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_cnt_r   <= (CNT_W > CNT_OUT_W && sched_r > CNT_W'({CNT_OUT_W{1'b1}})) ?
                           {CNT_OUT_W{1'b1}} : CNT_OUT_W'(sched_r);
            out_tot_r   <= TOT_OUT_W'(tot_sat);
            out_ovf_r   <= ovf_r;
            count_r     <= '0;
            ovf_r       <= 1'b0;
            state_r     <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_scheduled_count = out_cnt_r;
  assign out_total_profit    = out_tot_r;
  assign out_overflow        = out_ovf_r;

  // The store never holds more jobs than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT) else $error("job count above capacity");

  // A slot probe always has a nonzero slot number.
  a_slot_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SLT_CHK) |-> (slot_r != '0)) else $error("slot probe at zero");

  // Scheduling never places more jobs than are stored.
  a_sched_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (sched_r <= count_r)) else $error("too many scheduled");

  // A result is only raised from the finishing state.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN)) else $error("stray result");

endmodule

// ===== sim/jdgs_checker.sv =====
// Checker for the job deadline greedy scheduler: predicts each set's result and compares.
`timescale 1ns / 1ps

module jdgs_checker
  import jdgs_pkg::*;
#(
  parameter int MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [DL_W-1:0]      in_job_deadline,
  input  logic [PR_W-1:0]      in_job_profit,
  input  logic                 in_last_job,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [CNT_OUT_W-1:0] out_scheduled_count,
  input  logic [TOT_OUT_W-1:0] out_total_profit,
  input  logic                 out_overflow,
  output int                   fail_count,
  output int                   pending_sets,
  output int                   sets_checked
);

  typedef struct {
    logic [CNT_OUT_W-1:0] count;
    logic [TOT_OUT_W-1:0] profit;
    logic                 overflow;
  } set_result_t;

  job_t        held_jobs[MAX_JOBS];
  int          held_count;
  logic        jobs_dropped;
  set_result_t expected_results[$];

  // Greedy sequencing over the jobs held for the current set.
  function automatic set_result_t schedule_held_jobs();
    int          by_profit[MAX_JOBS];
    logic        slot_busy[MAX_JOBS];
    int          k;
    int          cur;
    int          d;
    longint      total;
    int          count;
    set_result_t r;
    total = 0;
    count = 0;
    // Stable insertion sort, highest profit first.
    for (int i = 0; i < held_count; i++) begin
      k = i;
      while (k > 0 && held_jobs[by_profit[k-1]].profit < held_jobs[i].profit) begin
        by_profit[k] = by_profit[k-1];
        k--;
      end
      by_profit[k] = i;
    end
    for (int i = 0; i < MAX_JOBS; i++) slot_busy[i] = 1'b0;
    // Each job takes the latest free slot at or before its clamped deadline.
    for (int i = 0; i < held_count; i++) begin
      cur = by_profit[i];
      d = held_jobs[cur].deadline;
      if (d > held_count) d = held_count;
      while (d > 0) begin
        if (!slot_busy[d-1]) begin
          slot_busy[d-1] = 1'b1;
          count++;
          total += held_jobs[cur].profit;
          break;
        end
        d--;
      end
    end
    r.count    = (count > 511) ? 9'd511 : count[CNT_OUT_W-1:0];
    r.profit   = (total > 64'hFFFFFF) ? 24'hFFFFFF : total[TOT_OUT_W-1:0];
    r.overflow = jobs_dropped;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    fail_count++;
  endtask

  // Watch both channels at each rising edge.
  always @(posedge clk) begin
    set_result_t want;
    if (!rst_n) begin
      held_count   = 0;
      jobs_dropped = 1'b0;
    end else begin
      // Accepted request: store it, and schedule the set when it closes.
      if (in_valid && !in_stall) begin
        if (held_count < MAX_JOBS) begin
          held_jobs[held_count].deadline = in_job_deadline;
          held_jobs[held_count].profit   = in_job_profit;
          held_count = held_count + 1;
        end else begin
          jobs_dropped = 1'b1;
        end
        if (in_last_job) begin
          expected_results = {expected_results, schedule_held_jobs()};
          held_count   = 0;
          jobs_dropped = 1'b0;
        end
      end
      // Accepted result: compare against the oldest expectation.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("[%0t] result with no set closed", $time);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          sets_checked++;
          if (out_scheduled_count !== want.count)
            report_mismatch("scheduled_count", out_scheduled_count, want.count);
          if (out_total_profit !== want.profit)
            report_mismatch("total_profit", out_total_profit, want.profit);
          if (out_overflow !== want.overflow)
            report_mismatch("overflow", out_overflow, want.overflow);
        end
      end
    end
    pending_sets <= expected_results.size();
  end

  initial begin
    fail_count   = 0;
    pending_sets = 0;
    sets_checked = 0;
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the job deadline greedy scheduler testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import jdgs_pkg::*;

  localparam int STALL_LIMIT = 600000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [DL_W-1:0]      in_job_deadline;
  logic [PR_W-1:0]      in_job_profit;
  logic                 in_last_job;
  logic                 out_valid;
  logic                 out_stall;
  logic [CNT_OUT_W-1:0] out_scheduled_count;
  logic [TOT_OUT_W-1:0] out_total_profit;
  logic                 out_overflow;
  int                   fail_count;
  int                   pending_sets;
  int                   sets_checked;
  int                   jobs_sent;
  int                   quiet_cycles;
  logic                 calm;

  job_deadline_greedy_scheduler dut (.*);

  jdgs_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side stalls in random bursts until the closing stretch.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too long with no request or result accepted.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d sets outstanding", pending_sets);
      $display("job_deadline_greedy_scheduler regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one job and hold it until accepted, sometimes idling afterwards.
  task automatic send_job(input logic [DL_W-1:0] dl, input logic [PR_W-1:0] pr,
                          input logic last);
    in_valid        <= 1'b1;
    in_job_deadline <= dl;
    in_job_profit   <= pr;
    in_last_job     <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    jobs_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // One set of random jobs; narrow profits make ties, narrow deadlines make contention.
  task automatic send_random_set(input int n);
    logic [DL_W-1:0] dl;
    logic [PR_W-1:0] pr;
    int              style;
    style = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      dl = (style == 0) ? DL_W'($urandom) : DL_W'($urandom_range(0, n + 2));
      pr = (style == 1) ? PR_W'($urandom_range(0, 3)) : PR_W'($urandom);
      send_job(dl, pr, i == n - 1);
    end
  endtask

  initial begin
    in_valid        = 1'b0;
    in_job_deadline = '0;
    in_job_profit   = '0;
    in_last_job     = 1'b0;
    rst_n           = 1'b0;
    calm            = 1'b0;
    jobs_sent       = 0;
    quiet_cycles    = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets: zero deadline, widest fields, ties, contention for one slot.
    send_job(10'd0, 16'hFFFF, 1'b1);
    send_job(10'h3FF, 16'hFFFF, 1'b1);
    send_job(10'h3FF, 16'h0000, 1'b0);
    send_job(10'd0, 16'hFFFF, 1'b1);
    for (int i = 0; i < 4; i++) send_job(10'd2, 16'h8000, i == 3);
    for (int i = 0; i < 5; i++) send_job(10'd1, PR_W'(i * 100), i == 4);
    send_job(10'd3, 16'd5, 1'b0);
    send_job(10'd1, 16'd9, 1'b0);
    send_job(10'd2, 16'd7, 1'b0);
    send_job(10'h2AA, 16'h5555, 1'b0);
    send_job(10'h155, 16'hAAAA, 1'b1);

    // Let every result drain before going on; the count of open sets is a registered value.
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_sets == 0);
    @(posedge clk);

    // Full store with two jobs dropped, the last of them closing the set.
    for (int i = 0; i < 258; i++)
      send_job(DL_W'($urandom_range(0, 300)), PR_W'($urandom), i == 257);
    // Exactly full store, no drops.
    send_random_set(256);

    // Random small sets.
    while (jobs_sent < 1150) begin
      if (jobs_sent > 1050) calm = 1'b1;
      send_random_set($urandom_range(1, 12));
    end

    in_valid <= 1'b0;
    calm = 1'b1;
    @(posedge clk);
    wait (pending_sets == 0);
    repeat (100) @(posedge clk);

    $display("Sent %0d jobs in sets of 1 to 258, including full-store and dropped-job sets;",
             jobs_sent);
    $display("%0d set results compared, %0d mismatches.", sets_checked, fail_count);
    if (fail_count == 0) begin
      $display("job_deadline_greedy_scheduler regression: pass");
    end else begin
      $display("job_deadline_greedy_scheduler regression: fail");
    end
    $finish;
  end

endmodule

// ===== job_deadline_greedy_scheduler.f =====
design/jdgs_pkg.sv
design/job_deadline_greedy_scheduler.sv
sim/jdgs_checker.sv
sim/testbench.sv
